[hw/rtl/proximity_velocity_damper_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the proximity velocity damper
// Implication checks, active in simulation and empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef PROXIMITY_VELOCITY_DAMPER_ASSERT_SVH
`define PROXIMITY_VELOCITY_DAMPER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define PVD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pvd: same-cycle check failed");
// next-cycle implication
`define PVD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pvd: next-cycle check failed");
`else
`define PVD_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define PVD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/pvd_pkg.sv]
// ----------------------------------------------------------------------------
// pvd_pkg
// Shared types, constants and the band factor table of the damper.
// ----------------------------------------------------------------------------
package pvd_pkg;

   localparam int COLUMNS_DEF     = 13;
   localparam int WINDOW_DEF      = 5;
   localparam int COUNT_WIDTH_DEF = 16;

   localparam int BANDS      = 3;
   localparam int TABLE_COLS = 13;
   localparam int REG_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int COL_IDX_W  = 6;
   localparam int FACTOR_W   = 10;
   localparam int SCAN_SUM_W = 16;
   localparam int Q15_W      = 17;
   localparam int DATA_W     = 48;

   localparam logic [Q15_W-1:0] ONE_Q15 = 17'h08000;
   localparam logic [REG_W-1:0] IDX_MAX = 16'hFFFF;

   localparam logic [REG_W-1:0] SPS_RESET  = 16'd720;
   localparam logic [REG_W-1:0] FAR_RESET  = 16'd3000;
   localparam logic [REG_W-1:0] MID_RESET  = 16'd2000;
   localparam logic [REG_W-1:0] NEAR_RESET = 16'd1000;
   localparam logic [REG_W-1:0] HCM_RESET  = 16'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLES_PER_SCAN = 3'd0,
      CSR_FAR_LIMIT        = 3'd1,
      CSR_MID_LIMIT        = 3'd2,
      CSR_NEAR_LIMIT       = 3'd3,
      CSR_HIT_COUNT_MIN    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      BAND_FAR  = 2'd0,
      BAND_MID  = 2'd1,
      BAND_NEAR = 2'd2
   } band_type;

   typedef enum logic {
      FUNC_RANGE    = 1'b0,
      FUNC_VELOCITY = 1'b1
   } func_type;

   typedef enum logic {
      KIND_REPORT   = 1'b0,
      KIND_VELOCITY = 1'b1
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BIN_MUL,
      ST_BIN_STEP,
      ST_BIN_WRITE,
      ST_WALK,
      ST_WALK_DRAIN,
      ST_WIN,
      ST_DIV_MUL,
      ST_DIV_FIX,
      ST_VEL_MUL,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic col_mul;
      logic col_step;
      logic cell_write;
      logic walk_start;
      logic walk_step;
      logic win_update;
      logic div_mul;
      logic div_fix;
      logic vel_mul;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_end;
      logic walk_last;
      logic need_div;
      logic avg_ready;
      logic out_free;
   } ctrl_stat_type;

   // Q1.15 factors, rows far / middle / near
   localparam logic [FACTOR_W-1:0] FACTOR_TABLE [BANDS][TABLE_COLS] = '{
      '{10'd0, 10'd0, 10'd0, 10'd328, 10'd655, 10'd655, 10'd983,
        10'd655, 10'd655, 10'd328, 10'd0, 10'd0, 10'd0},
      '{10'd0, 10'd0, 10'd0, 10'd328, 10'd328, 10'd655, 10'd655,
        10'd655, 10'd328, 10'd328, 10'd0, 10'd0, 10'd0},
      '{10'd0, 10'd0, 10'd0, 10'd0, 10'd328, 10'd328, 10'd655,
        10'd328, 10'd328, 10'd0, 10'd0, 10'd0, 10'd0}
   };

   // columns past the table carry no factor
   function automatic logic [FACTOR_W-1:0] band_factor(input logic [1:0] band,
                                                       input logic [COL_IDX_W-1:0] col);
      logic [FACTOR_W-1:0] f;
      f = '0;
      if (band < 2'(BANDS) && col < COL_IDX_W'(TABLE_COLS)) begin
         f = FACTOR_TABLE[band][col[3:0]];
      end
      return f;
   endfunction

endpackage

[hw/rtl/pvd_ram.sv]
// ----------------------------------------------------------------------------
// pvd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pvd_ram #(
   parameter int WIDTH = pvd_pkg::COUNT_WIDTH_DEF,
   parameter int DEPTH = pvd_pkg::BANDS * pvd_pkg::COLUMNS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/pvd_ctrl.sv]
// ----------------------------------------------------------------------------
// pvd_ctrl
// Sequencer: bins a sample, walks the histogram at scan end, updates the
// average, scales velocity commands and issues results.
// ----------------------------------------------------------------------------
`include "proximity_velocity_damper_assert.svh"

module pvd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_func,
   output logic                   req_tready,
   output pvd_pkg::ctrl_cmd_type  cmd,
   input  pvd_pkg::ctrl_stat_type stat
);

   pvd_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pvd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         pvd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_func == pvd_pkg::FUNC_VELOCITY) begin
                  // drop commands until the average is primed
                  if (stat.avg_ready) begin
                     state_in = pvd_pkg::ST_VEL_MUL;
                  end
               end else begin
                  state_in = pvd_pkg::ST_BIN_MUL;
               end
            end
         end
         pvd_pkg::ST_BIN_MUL: begin
            cmd.col_mul = 1'b1;
            state_in    = pvd_pkg::ST_BIN_STEP;
         end
         pvd_pkg::ST_BIN_STEP: begin
            cmd.col_step = 1'b1;
            state_in     = pvd_pkg::ST_BIN_WRITE;
         end
         pvd_pkg::ST_BIN_WRITE: begin
            cmd.cell_write = 1'b1;
            if (stat.scan_end) begin
               cmd.walk_start = 1'b1;
               state_in       = pvd_pkg::ST_WALK;
            end else begin
               state_in = pvd_pkg::ST_IDLE;
            end
         end
         pvd_pkg::ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (stat.walk_last) begin
               state_in = pvd_pkg::ST_WALK_DRAIN;
            end
         end
         pvd_pkg::ST_WALK_DRAIN: begin
            state_in = pvd_pkg::ST_WIN;
         end
         pvd_pkg::ST_WIN: begin
            cmd.win_update = 1'b1;
            state_in       = stat.need_div ? pvd_pkg::ST_DIV_MUL : pvd_pkg::ST_EMIT;
         end
         pvd_pkg::ST_DIV_MUL: begin
            cmd.div_mul = 1'b1;
            state_in    = pvd_pkg::ST_DIV_FIX;
         end
         pvd_pkg::ST_DIV_FIX: begin
            cmd.div_fix = 1'b1;
            state_in    = pvd_pkg::ST_EMIT;
         end
         pvd_pkg::ST_VEL_MUL: begin
            cmd.vel_mul = 1'b1;
            state_in    = pvd_pkg::ST_EMIT;
         end
         pvd_pkg::ST_EMIT: begin
            // hold until the output register can take the item
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = pvd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pvd_pkg::ST_IDLE;
         end
      endcase
   end

   `PVD_ASSERT_IMPL(a_emit_free, clock, reset, cmd.emit, stat.out_free)
   `PVD_ASSERT_IMPL(a_walk_last_in_walk, clock, reset, stat.walk_last, state_ff == pvd_pkg::ST_WALK)

endmodule

[hw/rtl/pvd_datapath.sv]
// ----------------------------------------------------------------------------
// pvd_datapath
// Registers, histogram store, column walk, moving average and scaling.
// ----------------------------------------------------------------------------
`include "proximity_velocity_damper_assert.svh"

module pvd_datapath #(
   parameter int COLUMNS     = pvd_pkg::COLUMNS_DEF,
   parameter int WINDOW      = pvd_pkg::WINDOW_DEF,
   parameter int COUNT_WIDTH = pvd_pkg::COUNT_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [pvd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pvd_pkg::REG_W-1:0]         csr_wdata,
   input  logic                              in_func,
   input  logic                              in_last,
   input  logic [pvd_pkg::REG_W-1:0]         in_range,
   input  logic signed [pvd_pkg::REG_W-1:0]  in_linear,
   input  logic signed [pvd_pkg::REG_W-1:0]  in_angular,
   input  pvd_pkg::ctrl_cmd_type             cmd,
   output pvd_pkg::ctrl_stat_type            stat,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [pvd_pkg::DATA_W-1:0]        rsp_tdata,
   output logic                              rsp_tuser
);

   localparam int COL_W   = $clog2(COLUMNS);
   localparam int COLP1_W = $clog2(COLUMNS + 1);
   localparam int MUL_W   = pvd_pkg::REG_W + COLP1_W;
   localparam int CELLS   = pvd_pkg::BANDS * COLUMNS;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int FILL_W  = $clog2(WINDOW + 1);
   localparam int SUM_W   = $clog2(WINDOW * 32768 + 1);
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam int CMP_W   = (COUNT_WIDTH > pvd_pkg::REG_W) ? COUNT_WIDTH : pvd_pkg::REG_W;
   localparam int VPROD_W = 2 * pvd_pkg::REG_W + 1;
   localparam int RW      = pvd_pkg::REG_W;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [COL_W-1:0]       LAST_COL  = COL_W'(COLUMNS - 1);
   localparam logic [MUL_W-1:0]       COLUMNS_M = MUL_W'(COLUMNS);
   localparam logic [RECIP_W-1:0]     RECIP     = RECIP_W'((64'd1 << SUM_W) / WINDOW);

   // configuration
   logic [RW-1:0] sps_ff, sps_in, far_ff, far_in, mid_ff, mid_in;
   logic [RW-1:0] near_ff, near_in, hcm_ff, hcm_in;

   // captured item
   logic                 func_ff, func_in, last_ff, last_in;
   logic [RW-1:0]        range_ff, range_in;
   logic signed [RW-1:0] lin_ff, lin_in, ang_ff, ang_in;

   // binning
   logic [MUL_W-1:0]  lhs_ff, lhs_in, rhs_ff, rhs_in;
   pvd_pkg::band_type band_ff, band_in;
   logic              skip_ff, skip_in;
   logic [RW-1:0]     idx_ff, idx_in;
   logic [COL_W-1:0]  col_ff, col_in, col_next;
   logic              adv;
   logic [ADDR_W-1:0] cell_addr_ff, cell_addr_in, cell_addr_calc;
   logic [CELLS-1:0]  hist_valid_ff, hist_valid_in;
   logic              rd_valid_ff, rd_valid_in;

   // histogram store access
   logic                   ram_we;
   logic [ADDR_W-1:0]      ram_raddr, walk_addr;
   logic [COUNT_WIDTH-1:0] ram_rdata, cell_count, cell_inc;

   // column walk
   logic [COL_W-1:0]          walk_col_ff, walk_col_in, ev_col_ff, ev_col_in;
   pvd_pkg::band_type         walk_band_ff, walk_band_in, ev_band_ff, ev_band_in;
   logic                      ev_v_ff, ev_v_in, hit_ff, hit_in, hit_now, qualify;
   logic [pvd_pkg::SCAN_SUM_W-1:0] scan_sum_ff, scan_sum_in;
   logic [pvd_pkg::Q15_W-1:0] scan_q15;
   logic [RW-1:0]             scan_value;

   // moving average
   logic [RW-1:0]     win_ff [WINDOW];
   logic [RW-1:0]     win_in [WINDOW];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              ready_ff, ready_in;
   logic [SUM_W-1:0]  wsum_ff, wsum_in;
   logic [RW-1:0]     avg_ff, avg_in;
   logic [PROD_W-1:0] div_prod_ff, div_prod_in;
   logic [SUM_W-1:0]  q0, q0_times, rem, q_fix;

   // velocity scaling
   logic signed [VPROD_W-1:0] lin_prod_ff, lin_prod_in, ang_prod_ff, ang_prod_in;
   logic signed [RW:0]        avg_s;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in, rsp_kind_ff, rsp_kind_in;
   logic [pvd_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RW-1:0]             lin_out, ang_out;

   // ---------------- configuration ----------------
   always_comb begin
      sps_in  = sps_ff;
      far_in  = far_ff;
      mid_in  = mid_ff;
      near_in = near_ff;
      hcm_in  = hcm_ff;
      if (csr_we) begin
         case (csr_index)
            pvd_pkg::CSR_SAMPLES_PER_SCAN: sps_in  = csr_wdata;
            pvd_pkg::CSR_FAR_LIMIT:        far_in  = csr_wdata;
            pvd_pkg::CSR_MID_LIMIT:        mid_in  = csr_wdata;
            pvd_pkg::CSR_NEAR_LIMIT:       near_in = csr_wdata;
            pvd_pkg::CSR_HIT_COUNT_MIN:    hcm_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // ---------------- item capture and binning ----------------
   always_comb begin
      func_in  = cmd.load ? in_func    : func_ff;
      last_in  = cmd.load ? in_last    : last_ff;
      range_in = cmd.load ? in_range   : range_ff;
      lin_in   = cmd.load ? in_linear  : lin_ff;
      ang_in   = cmd.load ? in_angular : ang_ff;
   end

   always_comb begin
      lhs_in  = lhs_ff;
      rhs_in  = rhs_ff;
      band_in = band_ff;
      skip_in = skip_ff;
      if (cmd.col_mul) begin
         lhs_in  = MUL_W'(idx_ff) * COLUMNS_M;
         rhs_in  = (MUL_W'(col_ff) + MUL_W'(1)) * MUL_W'(sps_ff);
         skip_in = (range_ff == '0) || (range_ff > far_ff);
         if (range_ff > mid_ff) begin
            band_in = pvd_pkg::BAND_FAR;
         end else if (range_ff > near_ff) begin
            band_in = pvd_pkg::BAND_MID;
         end else begin
            band_in = pvd_pkg::BAND_NEAR;
         end
      end
   end

   assign adv            = (lhs_ff > rhs_ff) && (col_ff != LAST_COL);
   assign col_next       = col_ff + COL_W'(adv);
   assign cell_addr_calc = ADDR_W'(32'(band_ff) * COLUMNS + 32'(col_next));
   assign walk_addr      = ADDR_W'(32'(walk_band_ff) * COLUMNS + 32'(walk_col_ff));

   assign cell_count = rd_valid_ff ? ram_rdata : '0;
   assign cell_inc   = (cell_count == COUNT_MAX) ? cell_count : cell_count + 1'b1;
   assign ram_we     = cmd.cell_write && !skip_ff;
   assign ram_raddr  = cmd.walk_step ? walk_addr : cell_addr_calc;
   assign rd_valid_in = hist_valid_ff[ram_raddr];

   always_comb begin
      idx_in        = idx_ff;
      col_in        = col_ff;
      cell_addr_in  = cell_addr_ff;
      hist_valid_in = hist_valid_ff;
      if (cmd.col_step) begin
         col_in       = col_next;
         cell_addr_in = cell_addr_calc;
         if (idx_ff != pvd_pkg::IDX_MAX) begin
            idx_in = idx_ff + 1'b1;
         end
      end
      if (cmd.win_update) begin
         // scan closed: clear histogram and position
         idx_in        = '0;
         col_in        = '0;
         hist_valid_in = '0;
      end else if (ram_we) begin
         hist_valid_in[cell_addr_ff] = 1'b1;
      end
   end

   pvd_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (CELLS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cell_addr_ff),
      .wr_data (cell_inc),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ---------------- column walk ----------------
   // near band first; once a band qualifies, it and every farther band add
   always_comb begin
      walk_col_in  = walk_col_ff;
      walk_band_in = walk_band_ff;
      if (cmd.walk_start) begin
         walk_col_in  = '0;
         walk_band_in = pvd_pkg::BAND_NEAR;
      end else if (cmd.walk_step) begin
         if (walk_band_ff == pvd_pkg::BAND_FAR) begin
            walk_band_in = pvd_pkg::BAND_NEAR;
            walk_col_in  = (walk_col_ff == LAST_COL) ? '0 : walk_col_ff + 1'b1;
         end else begin
            walk_band_in = pvd_pkg::band_type'(walk_band_ff - 2'd1);
         end
      end
   end

   assign ev_v_in    = cmd.walk_step;
   assign ev_band_in = walk_band_ff;
   assign ev_col_in  = walk_col_ff;
   assign qualify    = CMP_W'(cell_count) >= CMP_W'(hcm_ff);
   assign hit_now    = qualify || ((ev_band_ff != pvd_pkg::BAND_NEAR) && hit_ff);

   always_comb begin
      hit_in      = hit_ff;
      scan_sum_in = scan_sum_ff;
      if (cmd.walk_start) begin
         hit_in      = 1'b0;
         scan_sum_in = '0;
      end else if (ev_v_ff) begin
         hit_in = hit_now;
         if (hit_now) begin
            scan_sum_in = scan_sum_ff + pvd_pkg::SCAN_SUM_W'(
               pvd_pkg::band_factor(ev_band_ff, pvd_pkg::COL_IDX_W'(ev_col_ff)));
         end
      end
   end

   assign scan_q15   = (pvd_pkg::Q15_W'(scan_sum_ff) >= pvd_pkg::ONE_Q15) ? '0
                     : pvd_pkg::ONE_Q15 - pvd_pkg::Q15_W'(scan_sum_ff);
   assign scan_value = scan_q15[RW-1:0];

   // ---------------- moving average ----------------
   always_comb begin
      win_in   = win_ff;
      fill_in  = fill_ff;
      ready_in = ready_ff;
      wsum_in  = wsum_ff;
      if (cmd.win_update) begin
         if (!ready_ff && fill_ff == FILL_W'(WINDOW)) begin
            ready_in = 1'b1;
         end else begin
            for (int i = 0; i < WINDOW - 1; i++) begin
               win_in[i] = win_ff[i + 1];
            end
            win_in[WINDOW - 1] = scan_value;
            if (ready_ff) begin
               wsum_in = wsum_ff - SUM_W'(win_ff[0]) + SUM_W'(scan_value);
            end else begin
               fill_in = fill_ff + 1'b1;
               wsum_in = wsum_ff + SUM_W'(scan_value);
            end
         end
      end
   end

   // floor(sum / WINDOW): reciprocal estimate, then one correction
   assign div_prod_in = cmd.div_mul ? PROD_W'(wsum_ff) * PROD_W'(RECIP) : div_prod_ff;
   assign q0          = SUM_W'(div_prod_ff[PROD_W-1:SUM_W]);
   assign q0_times    = q0 * SUM_W'(WINDOW);
   assign rem         = wsum_ff - q0_times;
   assign q_fix       = (rem >= SUM_W'(WINDOW)) ? q0 + 1'b1 : q0;
   assign avg_in      = cmd.div_fix ? q_fix[RW-1:0] : avg_ff;

   // ---------------- velocity scaling ----------------
   assign avg_s = signed'({1'b0, avg_ff});

   always_comb begin
      lin_prod_in = lin_prod_ff;
      ang_prod_in = ang_prod_ff;
      if (cmd.vel_mul) begin
         lin_prod_in = VPROD_W'(lin_ff) * VPROD_W'(avg_s);
         ang_prod_in = VPROD_W'(ang_ff) * VPROD_W'(avg_s);
      end
   end

   // ---------------- output register ----------------
   assign lin_out = (func_ff == pvd_pkg::FUNC_VELOCITY) ? lin_prod_ff[2*RW-2:RW-1] : '0;
   assign ang_out = (func_ff == pvd_pkg::FUNC_VELOCITY) ? ang_prod_ff[2*RW-2:RW-1] : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = (func_ff == pvd_pkg::FUNC_VELOCITY) ? pvd_pkg::KIND_VELOCITY
                                                            : pvd_pkg::KIND_REPORT;
         rsp_data_in  = {ang_out, lin_out, avg_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign stat.scan_end  = last_ff;
   assign stat.walk_last = (walk_col_ff == LAST_COL) && (walk_band_ff == pvd_pkg::BAND_FAR);
   assign stat.need_div  = ready_ff || (fill_ff == FILL_W'(WINDOW));
   assign stat.avg_ready = ready_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         sps_ff        <= pvd_pkg::SPS_RESET;
         far_ff        <= pvd_pkg::FAR_RESET;
         mid_ff        <= pvd_pkg::MID_RESET;
         near_ff       <= pvd_pkg::NEAR_RESET;
         hcm_ff        <= pvd_pkg::HCM_RESET;
         idx_ff        <= '0;
         col_ff        <= '0;
         hist_valid_ff <= '0;
         walk_col_ff   <= '0;
         walk_band_ff  <= pvd_pkg::BAND_NEAR;
         ev_v_ff       <= 1'b0;
         fill_ff       <= '0;
         ready_ff      <= 1'b0;
         wsum_ff       <= '0;
         avg_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         sps_ff        <= sps_in;
         far_ff        <= far_in;
         mid_ff        <= mid_in;
         near_ff       <= near_in;
         hcm_ff        <= hcm_in;
         idx_ff        <= idx_in;
         col_ff        <= col_in;
         hist_valid_ff <= hist_valid_in;
         walk_col_ff   <= walk_col_in;
         walk_band_ff  <= walk_band_in;
         ev_v_ff       <= ev_v_in;
         fill_ff       <= fill_in;
         ready_ff      <= ready_in;
         wsum_ff       <= wsum_in;
         avg_ff        <= avg_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      last_ff      <= last_in;
      range_ff     <= range_in;
      lin_ff       <= lin_in;
      ang_ff       <= ang_in;
      lhs_ff       <= lhs_in;
      rhs_ff       <= rhs_in;
      band_ff      <= band_in;
      skip_ff      <= skip_in;
      cell_addr_ff <= cell_addr_in;
      rd_valid_ff  <= rd_valid_in;
      ev_band_ff   <= ev_band_in;
      ev_col_ff    <= ev_col_in;
      hit_ff       <= hit_in;
      scan_sum_ff  <= scan_sum_in;
      win_ff       <= win_in;
      div_prod_ff  <= div_prod_in;
      lin_prod_ff  <= lin_prod_in;
      ang_prod_ff  <= ang_prod_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_data_ff  <= rsp_data_in;
   end

   `PVD_ASSERT_IMPL(a_ready_full, clock, reset, ready_ff, fill_ff == FILL_W'(WINDOW))
   `PVD_ASSERT_IMPL(a_avg_q15, clock, reset, 1'b1, pvd_pkg::Q15_W'(avg_ff) <= pvd_pkg::ONE_Q15)
   `PVD_ASSERT_NEXT(a_scan_clear, clock, reset, cmd.win_update, idx_ff == '0 && hist_valid_ff == '0)

endmodule

[hw/rtl/proximity_velocity_damper.sv]
// ----------------------------------------------------------------------------
// proximity_velocity_damper
// Proximity histogram over angular columns and distance bands, averaged into
// a speed factor that scales velocity commands.
// ----------------------------------------------------------------------------
// Range sample: four steps (capture, column multiply, cell read, cell write),
//   set by the read-modify-write of the histogram RAM; one item at a time.
// Scan end: the histogram is walked one cell per cycle, then the average is
//   updated (with the divide once the window is full) and the report issued.
// Velocity command: captured, scaled and emitted before the next item; a
//   dropped one yields no result. Reset: synchronous, no clearing pass.
// ----------------------------------------------------------------------------
module proximity_velocity_damper #(
   parameter int COLUMNS     = pvd_pkg::COLUMNS_DEF,
   parameter int WINDOW      = pvd_pkg::WINDOW_DEF,
   parameter int COUNT_WIDTH = pvd_pkg::COUNT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // input items
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [pvd_pkg::DATA_W-1:0]    req_tdata,  // range_mm, linear_in, angular_in
   input  logic                          req_tuser,  // func
   input  logic                          req_tlast,  // last_sample
   // result items
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [pvd_pkg::DATA_W-1:0]    rsp_tdata,  // damping_factor, linear_out, angular_out
   output logic                          rsp_tuser,  // kind
   // configuration writes
   input  logic                          csr_we,
   input  logic [pvd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pvd_pkg::REG_W-1:0]     csr_wdata
);

   localparam int RW = pvd_pkg::REG_W;

   pvd_pkg::ctrl_cmd_type  cmd;
   pvd_pkg::ctrl_stat_type stat;

   logic [RW-1:0]        in_range;
   logic signed [RW-1:0] in_linear, in_angular;

   // unpack the item payload, lowest field first
   assign in_range   = req_tdata[RW-1:0];
   assign in_linear  = signed'(req_tdata[2*RW-1:RW]);
   assign in_angular = signed'(req_tdata[3*RW-1:2*RW]);

   // sequencer: one item at a time; the output register lets it take the
   // next item while a finished result still waits downstream
   pvd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // datapath: registers, histogram RAM, walk, average, scaling, output
   pvd_datapath #(
      .COLUMNS     (COLUMNS),
      .WINDOW      (WINDOW),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_func    (req_tuser),
      .in_last    (req_tlast),
      .in_range   (in_range),
      .in_linear  (in_linear),
      .in_angular (in_angular),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
